### rtl/core/assert_macros.svh
// -----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the chunked body deframer.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define CHBD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("chbd assertion failed");

// Next-cycle implication, disabled while reset is low
`define CHBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("chbd assertion failed");

`endif

### rtl/core/chbd_pkg.sv
// -----------------------------------------------------------------------------
// chbd_pkg
// Types, constants and helpers shared by the chunked body deframer.
// -----------------------------------------------------------------------------
package chbd_pkg;

    // Width of the length and chunk-size counters
    localparam int LENGTH_WIDTH = 32;
    localparam int HEX_BITS     = 4;
    localparam int CFG_WIDTH    = 32;

    typedef logic [LENGTH_WIDTH-1:0] len_t;
    typedef logic [CFG_WIDTH-1:0]    cfg_data_t;
    typedef logic [0:0]              cfg_index_t;

    // Register indexes
    localparam cfg_index_t REG_CHUNKED_MODE   = 1'd0;
    localparam cfg_index_t REG_CONTENT_LENGTH = 1'd1;

    // End status codes
    localparam logic [1:0] END_CONTINUE  = 2'd0;
    localparam logic [1:0] END_COMPLETE  = 2'd1;
    localparam logic [1:0] END_MALFORMED = 2'd2;

    // Characters of interest
    localparam logic [7:0] CHR_CR   = 8'h0D;
    localparam logic [7:0] CHR_LF   = 8'h0A;
    localparam logic [7:0] CHR_SEMI = 8'h3B;
    localparam logic [7:0] CHR_SP   = 8'h20;
    localparam logic [7:0] CHR_TAB  = 8'h09;

    // Input item as held by the input register
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } item_t;

    // Restart request from the register block
    typedef struct packed {
        logic restart;
        len_t len_load;
    } restart_t;

    // Result item
    typedef struct packed {
        logic [7:0] payload_byte;
        logic       payload_valid;
        logic [1:0] end_status;
    } result_t;

    // Hex decode: bit 4 is the valid flag, bits 3:0 the digit value
    function automatic logic [HEX_BITS:0] hex_decode(input logic [7:0] b);
        logic [HEX_BITS:0] r;
        r = '0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, 4'(b - 8'h30)};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            r = {1'b1, 4'(b - 8'h57)};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            r = {1'b1, 4'(b - 8'h37)};
        end
        return r;
    endfunction

    // Load value of the length counter, saturated to its width
    function automatic len_t sat_length(input cfg_data_t v);
        len_t r;
        if ((v >> LENGTH_WIDTH) != '0) begin
            r = '1;
        end else begin
            r = len_t'(v);
        end
        return r;
    endfunction

endpackage

### rtl/core/chbd_in_stage.sv
// -----------------------------------------------------------------------------
// chbd_in_stage
// Input register: captures one body byte and holds it until the engine takes it.
// -----------------------------------------------------------------------------
module chbd_in_stage (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [7:0]      s_body_byte,
    input  logic            take,
    output chbd_pkg::item_t item
);

    logic       valid_reg;
    logic [7:0] data_reg;

    // Free when empty or when the held item moves on this cycle
    assign s_ready = !valid_reg || take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            data_reg <= s_body_byte;
        end
    end

    assign item.valid = valid_reg;
    assign item.data  = data_reg;

endmodule

### rtl/core/chbd_cfg.sv
// -----------------------------------------------------------------------------
// chbd_cfg
// Configuration registers; any write restarts the body.
// -----------------------------------------------------------------------------
module chbd_cfg (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  chbd_pkg::cfg_index_t  cfg_index,
    input  chbd_pkg::cfg_data_t   cfg_wr_data,
    output logic                  chunked_mode,
    output chbd_pkg::restart_t    rst_req
);

    logic                chunked_mode_reg;
    chbd_pkg::cfg_data_t content_length_reg;

    // Register decode
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chunked_mode_reg   <= 1'b0;
            content_length_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                chbd_pkg::REG_CHUNKED_MODE:   chunked_mode_reg   <= cfg_wr_data[0];
                chbd_pkg::REG_CONTENT_LENGTH: content_length_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Restart carries the length that is valid after this write
    always_comb begin
        rst_req.restart  = cfg_wr_en;
        rst_req.len_load = chbd_pkg::sat_length(content_length_reg);
        if (cfg_index == chbd_pkg::REG_CONTENT_LENGTH) begin
            rst_req.len_load = chbd_pkg::sat_length(cfg_wr_data);
        end
    end

    assign chunked_mode = chunked_mode_reg;

endmodule

### rtl/core/chbd_engine.sv
// -----------------------------------------------------------------------------
// chbd_engine
// Per-byte framing state machine and result register.
// -----------------------------------------------------------------------------
module chbd_engine (
    input  logic               aclk,
    input  logic               aresetn,
    input  chbd_pkg::item_t    item,
    output logic               take,
    input  logic               chunked_mode,
    input  chbd_pkg::restart_t rst_req,
    output logic               m_valid,
    input  logic               m_ready,
    output chbd_pkg::result_t  result
);

    typedef enum logic [2:0] {
        PH_SIZE, PH_DATA, PH_TRAIL, PH_TRAIL_LF, PH_DONE, PH_BAD
    } phase_t;

    typedef struct packed {
        logic digit;
        logic after;
        logic ext;
        logic cr;
    } flags_t;

    localparam int LW = chbd_pkg::LENGTH_WIDTH;

    phase_t            phase_reg, phase_next;
    chbd_pkg::len_t    chunk_rem_reg, chunk_rem_next;
    chbd_pkg::len_t    size_val_reg, size_val_next;
    flags_t            flags_reg, flags_next;
    chbd_pkg::len_t    len_rem_reg, len_rem_next;
    logic              m_valid_reg;
    chbd_pkg::result_t result_reg;

    logic              res_v;
    chbd_pkg::result_t res;
    logic              fire;

    // Result register free: the engine can take the held byte
    assign take = !m_valid_reg || m_ready;
    assign fire = item.valid && take;

    // Next state and result for the held byte
    always_comb begin
        logic [7:0]                 b;
        logic                       do_size;
        logic                       handled;
        logic [chbd_pkg::HEX_BITS:0] hx;
        flags_t                     f;

        b              = item.data;
        do_size        = 1'b0;
        handled        = 1'b0;
        hx             = chbd_pkg::hex_decode(b);
        f              = flags_reg;
        phase_next     = phase_reg;
        chunk_rem_next = chunk_rem_reg;
        size_val_next  = size_val_reg;
        flags_next     = flags_reg;
        len_rem_next   = len_rem_reg;
        res_v          = 1'b0;
        res            = '0;

        if (phase_reg == PH_DONE || phase_reg == PH_BAD) begin
            // body over: byte dropped
        end else if (!chunked_mode) begin
            // fixed length mode
            res_v = 1'b1;
            if (len_rem_reg == '0) begin
                phase_next     = PH_DONE;
                res.end_status = chbd_pkg::END_COMPLETE;
            end else begin
                len_rem_next      = len_rem_reg - chbd_pkg::len_t'(1);
                res.payload_byte  = b;
                res.payload_valid = 1'b1;
                if (len_rem_reg == chbd_pkg::len_t'(1)) begin
                    phase_next     = PH_DONE;
                    res.end_status = chbd_pkg::END_COMPLETE;
                end
            end
        end else begin
            unique case (phase_reg)
                PH_DATA: begin
                    if (chunk_rem_reg == '0) begin
                        do_size = 1'b1;
                    end else begin
                        chunk_rem_next = chunk_rem_reg - chbd_pkg::len_t'(1);
                        if (chunk_rem_reg == chbd_pkg::len_t'(1)) begin
                            phase_next = PH_TRAIL;
                        end
                        res_v             = 1'b1;
                        res.payload_byte  = b;
                        res.payload_valid = 1'b1;
                    end
                end
                PH_TRAIL: begin
                    if (b == chbd_pkg::CHR_CR) begin
                        phase_next = PH_TRAIL_LF;
                    end else if (b == chbd_pkg::CHR_LF) begin
                        phase_next = PH_SIZE;
                    end else begin
                        do_size = 1'b1;
                    end
                end
                PH_TRAIL_LF: begin
                    if (b == chbd_pkg::CHR_LF) begin
                        phase_next = PH_SIZE;
                    end else begin
                        do_size = 1'b1;
                    end
                end
                PH_SIZE: do_size = 1'b1;
                default: do_size = 1'b1;
            endcase

            // chunk-size line parsing
            if (do_size) begin
                phase_next = PH_SIZE;
                if (f.cr) begin
                    if (b == chbd_pkg::CHR_LF) begin
                        handled = 1'b1;
                        if (!f.digit) begin
                            phase_next     = PH_BAD;
                            res_v          = 1'b1;
                            res.end_status = chbd_pkg::END_MALFORMED;
                        end else if (size_val_reg == '0) begin
                            phase_next     = PH_DONE;
                            f              = '0;
                            res_v          = 1'b1;
                            res.end_status = chbd_pkg::END_COMPLETE;
                        end else begin
                            chunk_rem_next = size_val_reg;
                            size_val_next  = '0;
                            f              = '0;
                            phase_next     = PH_DATA;
                        end
                    end else begin
                        // lone CR counts as whitespace
                        f.cr = 1'b0;
                        if (!f.ext && f.digit) begin
                            f.after = 1'b1;
                        end
                    end
                end
                if (!handled) begin
                    if (b == chbd_pkg::CHR_CR) begin
                        f.cr = 1'b1;
                    end else if (f.ext) begin
                        // extension text ignored
                    end else if (b == chbd_pkg::CHR_SEMI) begin
                        f.ext = 1'b1;
                    end else if (b == chbd_pkg::CHR_SP || b == chbd_pkg::CHR_TAB) begin
                        if (f.digit) begin
                            f.after = 1'b1;
                        end
                    end else if (!hx[chbd_pkg::HEX_BITS] || f.after
                                 || size_val_reg[LW-1 -: chbd_pkg::HEX_BITS] != '0) begin
                        phase_next     = PH_BAD;
                        res_v          = 1'b1;
                        res.end_status = chbd_pkg::END_MALFORMED;
                    end else begin
                        size_val_next = {size_val_reg[LW-chbd_pkg::HEX_BITS-1:0],
                                         hx[chbd_pkg::HEX_BITS-1:0]};
                        f.digit       = 1'b1;
                    end
                end
                flags_next = f;
            end
        end
    end

    // State, restart and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_SIZE;
            chunk_rem_reg <= '0;
            size_val_reg  <= '0;
            flags_reg     <= '0;
            len_rem_reg   <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (rst_req.restart) begin
                phase_reg     <= PH_SIZE;
                chunk_rem_reg <= '0;
                size_val_reg  <= '0;
                flags_reg     <= '0;
                len_rem_reg   <= rst_req.len_load;
            end else if (fire) begin
                phase_reg     <= phase_next;
                chunk_rem_reg <= chunk_rem_next;
                size_val_reg  <= size_val_next;
                flags_reg     <= flags_next;
                len_rem_reg   <= len_rem_next;
            end
            if (take) begin
                m_valid_reg <= fire && res_v && !rst_req.restart;
            end
        end
        if (fire && res_v) begin
            result_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign result  = result_reg;

endmodule

### rtl/core/http_chunked_body_deframer_top.sv
// -----------------------------------------------------------------------------
// http_chunked_body_deframer_top
// HTTP/1.1 message body deframer: fixed-length or chunked transfer decoding.
//
//   Channel  Direction  Handshake          Payload
//   s_       in         s_valid/s_ready    s_body_byte
//   m_       out        m_valid/m_ready    m_payload_byte, m_payload_valid,
//                                          m_end_status
//   cfg_     in         cfg_wr_en          cfg_index, cfg_wr_data
//
// One item per clock while the result side is not stalled; items pass the input
// register, then the framing state machine feeding the result register.
// Reset: aresetn, synchronous, active low; no clearing pass.
// A stalled result holds in the result register; the input register still
// absorbs one item, so s_ready drops only when both are full.
// Items that produce no result are consumed without touching the m_ side.
// -----------------------------------------------------------------------------
module http_chunked_body_deframer_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_body_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_payload_byte,
    output logic        m_payload_valid,
    output logic [1:0]  m_end_status,
    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_wr_data
);

    chbd_pkg::item_t    item;
    chbd_pkg::restart_t rst_req;
    chbd_pkg::result_t  result;
    logic               take;
    logic               chunked_mode;

    chbd_in_stage u_in (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_body_byte (s_body_byte),
        .take        (take),
        .item        (item)
    );

    chbd_cfg u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wr_data  (cfg_wr_data),
        .chunked_mode (chunked_mode),
        .rst_req      (rst_req)
    );

    chbd_engine u_eng (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .item         (item),
        .take         (take),
        .chunked_mode (chunked_mode),
        .rst_req      (rst_req),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .result       (result)
    );

    assign m_payload_byte  = result.payload_byte;
    assign m_payload_valid = result.payload_valid;
    assign m_end_status    = result.end_status;

endmodule

### rtl/core/chbd_checker.sv
// -----------------------------------------------------------------------------
// chbd_checker
// Port-level checks on the deframer's result stream, bound to the top level.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module chbd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_payload_byte,
    input logic        m_payload_valid,
    input logic [1:0]  m_end_status
);

    // Stalled result holds
    `CHBD_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_payload_byte) && $stable(m_payload_valid) && $stable(m_end_status))

    // Non-data results carry a zero byte and always mark end or error
    `CHBD_ASSERT_IMPLY(a_nodata, aclk, aresetn, m_valid && !m_payload_valid, m_payload_byte == 8'd0 && m_end_status != chbd_pkg::END_CONTINUE)

    // Malformed status never comes with data
    `CHBD_ASSERT_IMPLY(a_bad, aclk, aresetn, m_valid && m_end_status == chbd_pkg::END_MALFORMED, !m_payload_valid)

    // After the closing result is taken, the stream goes quiet
    `CHBD_ASSERT_NEXT(a_quiet, aclk, aresetn, m_valid && m_ready && m_end_status != chbd_pkg::END_CONTINUE, !m_valid)

endmodule

bind http_chunked_body_deframer_top chbd_checker u_chbd_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_payload_byte  (m_payload_byte),
    .m_payload_valid (m_payload_valid),
    .m_end_status    (m_end_status)
);

### dv/http_chunked_body_deframer_top_tb.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// http_chunked_body_deframer_top_tb
// Self-checking bench for the HTTP body deframer. A short directed list covers
// the length-mode extremes, size-line whitespace, extensions, lone-LF
// trailers, the zero chunk and the framing errors. Random bodies follow:
// mostly well-formed chunked bodies with random sizes, layout and data, plus
// length-mode bodies and broken sequences. Every accepted byte is run through
// an in-bench deframer and the result items are compared in order.
// -----------------------------------------------------------------------------
module http_chunked_body_deframer_top_tb;

    localparam int RX_HOLD_CYCLES = 80;
    localparam int DRAIN_CYCLES   = 4;
    localparam int TAIL_CYCLES    = 8;
    localparam int ITEM_TARGET    = 650;
    localparam int MAX_REPORTS    = 10;

    localparam logic [7:0] CHR_DIGIT0 = 8'h30;
    localparam logic [7:0] CHR_DIGIT9 = 8'h39;
    localparam logic [7:0] CHR_UC_A   = 8'h41;
    localparam logic [7:0] CHR_UC_F   = 8'h46;
    localparam logic [7:0] CHR_LC_A   = 8'h61;
    localparam logic [7:0] CHR_LC_F   = 8'h66;

    typedef enum logic [2:0] {
        ST_SIZE, ST_DATA, ST_TRAIL, ST_TRAIL_LF, ST_DONE, ST_BAD
    } body_state_t;

    typedef enum logic {ROW_BYTE, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t            kind;
        chbd_pkg::cfg_index_t idx;
        chbd_pkg::cfg_data_t  data;
        bit                   typed;
        chbd_pkg::result_t    want;
    } stim_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [7:0]           s_body_byte = 8'h00;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [7:0]           m_payload_byte;
    logic                 m_payload_valid;
    logic [1:0]           m_end_status;
    logic                 cfg_wr_en = 1'b0;
    chbd_pkg::cfg_index_t cfg_index = chbd_pkg::REG_CHUNKED_MODE;
    chbd_pkg::cfg_data_t  cfg_wr_data = '0;

    // Deframer state as the bench sees it
    logic                 mdl_chunked;
    chbd_pkg::cfg_data_t  mdl_content_len;
    body_state_t          mdl_phase;
    chbd_pkg::len_t       chunk_left;
    chbd_pkg::len_t       size_acc;
    chbd_pkg::len_t       len_left;
    logic                 digit_seen, after_digits, in_ext, cr_pending;

    chbd_pkg::result_t    exp_q[$];
    stim_row_t            stim_rows[$];
    logic [7:0]           body_q[$];
    int                   err_cnt = 0;
    int                   item_cnt = 0;

    // Receiver control
    logic                 no_idle = 1'b0;
    int                   hold_requests = 0;
    int                   hold_seen = 0;
    int                   hold_left = 0;

    chbd_pkg::result_t    seen_r, want_r;

    http_chunked_body_deframer_top u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_body_byte     (s_body_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_payload_byte  (m_payload_byte),
        .m_payload_valid (m_payload_valid),
        .m_end_status    (m_end_status),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data)
    );

    always #6 aclk = ~aclk;

    // -------------------------------------------------------------------------
    // Deframer prediction
    // -------------------------------------------------------------------------
    function automatic chbd_pkg::result_t make_result(logic [7:0] b, logic v, logic [1:0] s);
        chbd_pkg::result_t r;
        r.payload_byte  = b;
        r.payload_valid = v;
        r.end_status    = s;
        return r;
    endfunction

    function automatic void clear_line_flags();
        digit_seen   = 1'b0;
        after_digits = 1'b0;
        in_ext       = 1'b0;
        cr_pending   = 1'b0;
    endfunction

    // Any register write starts a new body
    function automatic void restart_body();
        mdl_phase  = ST_SIZE;
        chunk_left = '0;
        size_acc   = '0;
        clear_line_flags();
        if ((64'(mdl_content_len) >> chbd_pkg::LENGTH_WIDTH) != 64'd0) len_left = '1;
        else len_left = chbd_pkg::len_t'(mdl_content_len);
    endfunction

    function automatic void apply_reg(chbd_pkg::cfg_index_t idx, chbd_pkg::cfg_data_t d);
        if (idx == chbd_pkg::REG_CHUNKED_MODE) mdl_chunked = d[0];
        else mdl_content_len = d;
        restart_body();
    endfunction

    function automatic int hex_nibble(logic [7:0] b);
        if (b >= CHR_DIGIT0 && b <= CHR_DIGIT9) return int'(b - CHR_DIGIT0);
        if (b >= CHR_LC_A && b <= CHR_LC_F) return int'(b - CHR_LC_A) + 10;
        if (b >= CHR_UC_A && b <= CHR_UC_F) return int'(b - CHR_UC_A) + 10;
        return -1;
    endfunction

    function automatic bit framing_error(output chbd_pkg::result_t r);
        mdl_phase = ST_BAD;
        r = make_result(8'h00, 1'b0, chbd_pkg::END_MALFORMED);
        return 1'b1;
    endfunction

    // One byte of a chunk-size line; returns 1 when it yields a result
    function automatic bit size_line_byte(input logic [7:0] b, output chbd_pkg::result_t r);
        int nib;
        r = make_result(8'h00, 1'b0, chbd_pkg::END_CONTINUE);
        if (cr_pending) begin
            if (b == chbd_pkg::CHR_LF) begin
                if (!digit_seen) return framing_error(r);
                if (size_acc == '0) begin
                    // zero chunk: body ends here
                    mdl_phase = ST_DONE;
                    clear_line_flags();
                    r = make_result(8'h00, 1'b0, chbd_pkg::END_COMPLETE);
                    return 1'b1;
                end
                chunk_left = size_acc;
                size_acc   = '0;
                clear_line_flags();
                mdl_phase  = ST_DATA;
                return 1'b0;
            end
            // CR without LF acts as whitespace
            cr_pending = 1'b0;
            if (!in_ext && digit_seen) after_digits = 1'b1;
        end
        if (b == chbd_pkg::CHR_CR) begin
            cr_pending = 1'b1;
            return 1'b0;
        end
        if (in_ext) return 1'b0;
        if (b == chbd_pkg::CHR_SEMI) begin
            in_ext = 1'b1;
            return 1'b0;
        end
        if (b == chbd_pkg::CHR_SP || b == chbd_pkg::CHR_TAB) begin
            if (digit_seen) after_digits = 1'b1;
            return 1'b0;
        end
        nib = hex_nibble(b);
        if (nib < 0 || after_digits) return framing_error(r);
        if (size_acc[chbd_pkg::LENGTH_WIDTH-1 -: chbd_pkg::HEX_BITS] != '0) begin
            return framing_error(r);
        end
        size_acc   = {size_acc[chbd_pkg::LENGTH_WIDTH-chbd_pkg::HEX_BITS-1:0], 4'(nib)};
        digit_seen = 1'b1;
        return 1'b0;
    endfunction

    // One body byte; returns 1 when it yields a result item
    function automatic bit deframe_byte(input logic [7:0] b, output chbd_pkg::result_t r);
        r = make_result(8'h00, 1'b0, chbd_pkg::END_CONTINUE);
        if (mdl_phase == ST_DONE || mdl_phase == ST_BAD) return 1'b0;
        if (!mdl_chunked) begin
            if (len_left == '0) begin
                mdl_phase = ST_DONE;
                r = make_result(8'h00, 1'b0, chbd_pkg::END_COMPLETE);
                return 1'b1;
            end
            len_left = len_left - 1'b1;
            if (len_left == '0) begin
                mdl_phase = ST_DONE;
                r = make_result(b, 1'b1, chbd_pkg::END_COMPLETE);
            end else begin
                r = make_result(b, 1'b1, chbd_pkg::END_CONTINUE);
            end
            return 1'b1;
        end
        case (mdl_phase)
            ST_DATA: begin
                if (chunk_left == '0) begin
                    mdl_phase = ST_SIZE;
                    return size_line_byte(b, r);
                end
                chunk_left = chunk_left - 1'b1;
                if (chunk_left == '0) mdl_phase = ST_TRAIL;
                r = make_result(b, 1'b1, chbd_pkg::END_CONTINUE);
                return 1'b1;
            end
            ST_TRAIL: begin
                if (b == chbd_pkg::CHR_CR) begin
                    mdl_phase = ST_TRAIL_LF;
                    return 1'b0;
                end
                mdl_phase = ST_SIZE;
                if (b == chbd_pkg::CHR_LF) return 1'b0;
                return size_line_byte(b, r);
            end
            ST_TRAIL_LF: begin
                mdl_phase = ST_SIZE;
                if (b == chbd_pkg::CHR_LF) return 1'b0;
                return size_line_byte(b, r);
            end
            default: begin
                mdl_phase = ST_SIZE;
                return size_line_byte(b, r);
            end
        endcase
    endfunction

    // -------------------------------------------------------------------------
    // Body generation
    // -------------------------------------------------------------------------
    function automatic void add_blanks();
        if ($urandom_range(5) == 0) begin
            // stray CR that is not a line end
            body_q.push_back(chbd_pkg::CHR_CR);
            body_q.push_back(chbd_pkg::CHR_SP);
        end
        repeat ($urandom_range(1, 2)) begin
            body_q.push_back($urandom_range(1) ? chbd_pkg::CHR_SP : chbd_pkg::CHR_TAB);
        end
    endfunction

    function automatic void add_hex(chbd_pkg::len_t v);
        int nd;
        logic [3:0] nib;
        nd = 1;
        while (nd < chbd_pkg::LENGTH_WIDTH / chbd_pkg::HEX_BITS
               && (v >> (chbd_pkg::HEX_BITS * nd)) != '0) nd++;
        for (int i = nd - 1; i >= 0; i--) begin
            nib = v[chbd_pkg::HEX_BITS*i +: chbd_pkg::HEX_BITS];
            if (nib < 4'd10) body_q.push_back(CHR_DIGIT0 + nib);
            else if ($urandom_range(1)) body_q.push_back(CHR_UC_A + nib - 4'd10);
            else body_q.push_back(CHR_LC_A + nib - 4'd10);
        end
    endfunction

    function automatic void add_size_line(chbd_pkg::len_t v);
        logic [7:0] b;
        if ($urandom_range(99) < 25) add_blanks();
        if ($urandom_range(99) < 15) begin
            repeat ($urandom_range(1, 2)) body_q.push_back(CHR_DIGIT0);
        end
        add_hex(v);
        if ($urandom_range(99) < 25) add_blanks();
        if ($urandom_range(99) < 25) begin
            body_q.push_back(chbd_pkg::CHR_SEMI);
            repeat ($urandom_range(0, 6)) begin
                b = 8'($urandom_range(0, 255));
                body_q.push_back(b == chbd_pkg::CHR_LF ? chbd_pkg::CHR_SEMI : b);
            end
        end
        body_q.push_back(chbd_pkg::CHR_CR);
        body_q.push_back(chbd_pkg::CHR_LF);
    endfunction

    function automatic void add_chunked_body();
        int sz;
        repeat ($urandom_range(1, 4)) begin
            sz = ($urandom_range(99) < 8) ? int'($urandom_range(13, 40))
                                          : int'($urandom_range(1, 12));
            add_size_line(chbd_pkg::len_t'(sz));
            repeat (sz) body_q.push_back(8'($urandom_range(0, 255)));
            // chunk trailer: CR LF, lone LF, none, or a CR without LF
            case ($urandom_range(0, 3))
                0: begin
                    body_q.push_back(chbd_pkg::CHR_CR);
                    body_q.push_back(chbd_pkg::CHR_LF);
                end
                1: body_q.push_back(chbd_pkg::CHR_LF);
                2: ;
                default: body_q.push_back(chbd_pkg::CHR_CR);
            endcase
        end
        add_size_line('0);
        if ($urandom_range(99) < 30) begin
            repeat ($urandom_range(1, 5)) body_q.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    function automatic logic [7:0] noisy_byte();
        case ($urandom_range(0, 9))
            0: return chbd_pkg::CHR_CR;
            1: return chbd_pkg::CHR_LF;
            2: return chbd_pkg::CHR_SP;
            3: return chbd_pkg::CHR_TAB;
            4: return chbd_pkg::CHR_SEMI;
            5: return CHR_DIGIT0;
            6: return CHR_LC_A;
            7: return CHR_UC_F;
            8: return CHR_LC_F + 8'd1;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Broken or unusual bodies
    function automatic void add_noise();
        case ($urandom_range(0, 4))
            0: begin
                add_chunked_body();
                body_q[$urandom_range(0, body_q.size() - 1)] = 8'($urandom_range(0, 255));
            end
            1: begin
                // nine significant digits overflow the size
                add_hex(chbd_pkg::len_t'(32'h1000_0000 | $urandom));
                body_q.push_back(CHR_DIGIT0 + 8'd7);
                body_q.push_back(chbd_pkg::CHR_CR);
                body_q.push_back(chbd_pkg::CHR_LF);
                repeat (4) body_q.push_back(8'($urandom_range(0, 255)));
            end
            2: begin
                // largest size, body left unfinished
                add_size_line('1);
                repeat (20) body_q.push_back(8'($urandom_range(0, 255)));
            end
            3: repeat ($urandom_range(16, 40)) body_q.push_back(noisy_byte());
            default: begin
                // empty size line or lone LF
                if ($urandom_range(1)) add_blanks();
                if ($urandom_range(1)) body_q.push_back(chbd_pkg::CHR_CR);
                body_q.push_back(chbd_pkg::CHR_LF);
                body_q.push_back(8'($urandom_range(0, 255)));
            end
        endcase
    endfunction

    // -------------------------------------------------------------------------
    // Directed list
    // -------------------------------------------------------------------------
    function automatic void row_byte(logic [7:0] b);
        stim_rows.push_back('{ROW_BYTE, chbd_pkg::REG_CHUNKED_MODE,
                              chbd_pkg::cfg_data_t'(b), 1'b0, '0});
    endfunction

    function automatic void row_byte_exp(logic [7:0] b, chbd_pkg::result_t w);
        stim_rows.push_back('{ROW_BYTE, chbd_pkg::REG_CHUNKED_MODE,
                              chbd_pkg::cfg_data_t'(b), 1'b1, w});
    endfunction

    function automatic void row_write(chbd_pkg::cfg_index_t idx, chbd_pkg::cfg_data_t d);
        stim_rows.push_back('{ROW_WRITE, idx, d, 1'b0, '0});
    endfunction

    function automatic chbd_pkg::cfg_data_t mode_word(logic m);
        return (chbd_pkg::cfg_data_t'($urandom) & ~chbd_pkg::cfg_data_t'(1))
               | chbd_pkg::cfg_data_t'(m);
    endfunction

    // -------------------------------------------------------------------------
    // Drivers
    // -------------------------------------------------------------------------
    // Offer one body byte, wait for acceptance, then record what it should yield
    task automatic send_item(input logic [7:0] b, input bit typed,
                             input chbd_pkg::result_t want);
        chbd_pkg::result_t r;
        bit                yields;
        while (!no_idle && $urandom_range(99) < 22) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_body_byte <= b;
        do @(posedge aclk); while (!s_ready);
        yields = deframe_byte(b, r);
        if (typed) exp_q.push_back(want);
        else if (yields) exp_q.push_back(r);
        item_cnt++;
    endtask

    // Register write once the block has gone quiet
    task automatic write_reg(input chbd_pkg::cfg_index_t idx, input chbd_pkg::cfg_data_t d);
        s_valid <= 1'b0;
        while (exp_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= d;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        apply_reg(idx, d);
    endtask

    task automatic run_length_body();
        chbd_pkg::cfg_data_t len;
        int                  pick;
        int                  n;
        pick = int'($urandom_range(0, 9));
        if (pick == 0) len = '0;
        else if (pick == 1) len = '1;
        else if (pick == 2) len = $urandom;
        else len = $urandom_range(1, 24);
        write_reg(chbd_pkg::REG_CHUNKED_MODE, mode_word(1'b0));
        write_reg(chbd_pkg::REG_CONTENT_LENGTH, len);
        n = ((len > 24) ? 24 : int'(len)) + int'($urandom_range(0, 3));
        repeat (n) send_item(8'($urandom_range(0, 255)), 1'b0, '0);
    endtask

    task automatic run_chunked_body();
        write_reg(chbd_pkg::REG_CHUNKED_MODE, mode_word(1'b1));
        if ($urandom_range(3) == 0) write_reg(chbd_pkg::REG_CONTENT_LENGTH, $urandom);
        body_q.delete();
        if ($urandom_range(99) < 25) add_noise();
        else add_chunked_body();
        foreach (body_q[i]) send_item(body_q[i], 1'b0, '0);
    endtask

    // Long receiver hold while the sender keeps streaming
    task automatic run_backpressure();
        write_reg(chbd_pkg::REG_CHUNKED_MODE, mode_word(1'b0));
        write_reg(chbd_pkg::REG_CONTENT_LENGTH, 32'd300);
        no_idle       <= 1'b1;
        hold_requests <= hold_requests + 1;
        repeat (200) send_item(8'($urandom_range(0, 255)), 1'b0, '0);
        no_idle <= 1'b0;
    endtask

    // -------------------------------------------------------------------------
    // Result side: random stalls, plus one long hold on request
    // -------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_requests) begin
            m_ready   <= 1'b0;
            hold_seen <= hold_requests;
            hold_left <= RX_HOLD_CYCLES;
        end else if (no_idle) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= 22);
        end
    end

    task automatic note_error(input string msg);
        err_cnt++;
        if (err_cnt <= MAX_REPORTS) $display("%0t ERROR %s", $time, msg);
    endtask

    // Result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            seen_r = make_result(m_payload_byte, m_payload_valid, m_end_status);
            if (exp_q.size() == 0) begin
                note_error($sformatf("unexpected item byte=%02h valid=%0d status=%0d",
                                     seen_r.payload_byte, seen_r.payload_valid,
                                     seen_r.end_status));
            end else begin
                want_r = exp_q.pop_front();
                if (seen_r.payload_byte !== want_r.payload_byte ||
                    seen_r.payload_valid !== want_r.payload_valid ||
                    seen_r.end_status !== want_r.end_status) begin
                    note_error($sformatf(
                        "exp byte=%02h valid=%0d status=%0d, got byte=%02h valid=%0d status=%0d",
                        want_r.payload_byte, want_r.payload_valid, want_r.end_status,
                        seen_r.payload_byte, seen_r.payload_valid, seen_r.end_status));
                end
            end
        end
    end

    // -------------------------------------------------------------------------
    // Stimulus
    // -------------------------------------------------------------------------
    initial begin
        mdl_chunked     = 1'b0;
        mdl_content_len = '0;
        restart_body();

        // length mode, zero length straight after reset
        row_byte_exp(8'h00, make_result(8'h00, 1'b0, chbd_pkg::END_COMPLETE));
        row_byte(8'hFF);
        row_write(chbd_pkg::REG_CONTENT_LENGTH, 32'd1);
        row_byte_exp(8'hFF, make_result(8'hFF, 1'b1, chbd_pkg::END_COMPLETE));
        row_write(chbd_pkg::REG_CONTENT_LENGTH, 32'hFFFF_FFFF);
        row_byte_exp(8'h00, make_result(8'h00, 1'b1, chbd_pkg::END_CONTINUE));
        // chunked: blanks, extension, lone-LF trailer, zero chunk
        row_write(chbd_pkg::REG_CHUNKED_MODE, 32'd1);
        row_byte(chbd_pkg::CHR_SP);
        row_byte("1");
        row_byte(chbd_pkg::CHR_TAB);
        row_byte(chbd_pkg::CHR_SEMI);
        row_byte("!");
        row_byte(chbd_pkg::CHR_CR);
        row_byte(chbd_pkg::CHR_LF);
        row_byte(8'h80);
        row_byte(chbd_pkg::CHR_LF);
        row_byte("0");
        row_byte(chbd_pkg::CHR_CR);
        row_byte_exp(chbd_pkg::CHR_LF, make_result(8'h00, 1'b0, chbd_pkg::END_COMPLETE));
        // lone LF on the size line
        row_write(chbd_pkg::REG_CHUNKED_MODE, 32'd1);
        row_byte_exp(chbd_pkg::CHR_LF, make_result(8'h00, 1'b0, chbd_pkg::END_MALFORMED));
        // size overflow on the ninth digit
        row_write(chbd_pkg::REG_CHUNKED_MODE, 32'd1);
        repeat (8) row_byte("F");
        row_byte_exp("F", make_result(8'h00, 1'b0, chbd_pkg::END_MALFORMED));
        // digit after a CR that acted as whitespace
        row_write(chbd_pkg::REG_CHUNKED_MODE, 32'd1);
        row_byte("f");
        row_byte(chbd_pkg::CHR_CR);
        row_byte_exp("0", make_result(8'h00, 1'b0, chbd_pkg::END_MALFORMED));

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (stim_rows[i]) begin
            if (stim_rows[i].kind == ROW_WRITE) begin
                write_reg(stim_rows[i].idx, stim_rows[i].data);
            end else begin
                send_item(stim_rows[i].data[7:0], stim_rows[i].typed, stim_rows[i].want);
            end
        end

        run_backpressure();
        while (item_cnt < ITEM_TARGET) begin
            if ($urandom_range(99) < 30) run_length_body();
            else run_chunked_body();
        end

        s_valid <= 1'b0;
        while (exp_q.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (err_cnt == 0 && exp_q.size() == 0) begin
            $display("http_chunked_body_deframer_top_tb OK");
        end else begin
            $display("http_chunked_body_deframer_top_tb NOT OK");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("http_chunked_body_deframer_top_tb NOT OK");
        $finish;
    end

endmodule

### http_chunked_body_deframer_top.f
+incdir+rtl/core
rtl/core/chbd_pkg.sv
rtl/core/chbd_in_stage.sv
rtl/core/chbd_cfg.sv
rtl/core/chbd_engine.sv
rtl/core/http_chunked_body_deframer_top.sv
rtl/core/chbd_checker.sv
dv/http_chunked_body_deframer_top_tb.sv
